// File: rtl/nnsm_pkg.sv
// Package for the nearest-neighbour scale mapper.
// Holds the configuration codes, the fixed field widths and the settled-settings struct.
// No dependencies.
`timescale 1ns / 1ps

package nnsm_pkg;

  localparam int DIM_W     = 13;  // in_width, in_height register width
  localparam int SCALE_W   = 23;  // scale_factor register width
  localparam int FRAC_BITS = 16;  // fraction bits of the scale factor
  localparam int CFG_W     = 23;  // widest register
  localparam int ACC_W     = 36;  // accumulator width, index times factor
  localparam int PROD_W    = 36;  // dimension times factor
  localparam int EMIT_W    = 20;  // output columns emitted in a row
  localparam int CNT_W     = 7;   // copy count width
  localparam int PIX_W     = 24;
  localparam int SUM_W     = 38;  // accumulator plus factor plus rounding

  typedef enum logic [1:0] {
    CFG_IN_WIDTH     = 2'd0,
    CFG_IN_HEIGHT    = 2'd1,
    CFG_SCALE_FACTOR = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // Clamped settings and the output dimensions derived from them.
  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [SCALE_W-1:0] sf;
    logic [PROD_W-1:0]  wout;
    logic [PROD_W-1:0]  hout;
    logic               reduce;
  } nnsm_dims_t;

endpackage

// File: rtl/nnsm_pix_if.sv
// Input channel of the scale mapper: one 24-bit pixel per item.
// Depends on nnsm_pkg.
`timescale 1ns / 1ps

interface nnsm_pix_if
  import nnsm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: rtl/nnsm_res_if.sv
// Output channel of the scale mapper: pixel with its column and row copy counts.
// Depends on nnsm_pkg.
`timescale 1ns / 1ps

interface nnsm_res_if
  import nnsm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic [CNT_W-1:0] col_copies;
  logic [CNT_W-1:0] row_copies;
  logic             row_end;
  logic [1:0]       pad_bytes;
  logic             frame_end;

  modport source (output valid, output pixel_out, output col_copies, output row_copies,
                  output row_end, output pad_bytes, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input col_copies, input row_copies,
                  input row_end, input pad_bytes, input frame_end, output ready);
endinterface

// File: rtl/nnsm_cfg.sv
// Configuration registers of the scale mapper, with clamping and the output size product.
// Depends on nnsm_pkg.
`timescale 1ns / 1ps

module nnsm_cfg
  import nnsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output nnsm_dims_t       dims_o,
  output logic             busy_o
);

  localparam logic [31:0] MaxFactor = 32'(100) << FRAC_BITS;
  localparam logic [31:0] OneFx     = 32'(1) << FRAC_BITS;

  logic [DIM_W-1:0]   width_q, height_q;
  logic [SCALE_W-1:0] scale_q;
  logic               busy_q;
  nnsm_dims_t         dims_d, dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      scale_q  <= SCALE_W'(OneFx);
      busy_q   <= 1'b1;
    end else begin
      busy_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_IN_WIDTH:     width_q  <= cfg_wdata_i[DIM_W-1:0];
          CFG_IN_HEIGHT:    height_q <= cfg_wdata_i[DIM_W-1:0];
          CFG_SCALE_FACTOR: scale_q  <= cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    dims_d = '0;
    if (width_q == '0) begin
      dims_d.w = DIM_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      dims_d.w = DIM_W'(MAX_WIDTH);
    end else begin
      dims_d.w = width_q;
    end
    if (height_q == '0) begin
      dims_d.h = DIM_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      dims_d.h = DIM_W'(MAX_HEIGHT);
    end else begin
      dims_d.h = height_q;
    end
    if (scale_q == '0) begin
      dims_d.sf = SCALE_W'(1);
    end else if (32'(scale_q) > MaxFactor) begin
      dims_d.sf = SCALE_W'(MaxFactor);
    end else begin
      dims_d.sf = scale_q;
    end
    dims_d.wout   = (PROD_W'(dims_d.w) * PROD_W'(dims_d.sf)) >> FRAC_BITS;
    dims_d.hout   = (PROD_W'(dims_d.h) * PROD_W'(dims_d.sf)) >> FRAC_BITS;
    dims_d.reduce = 32'(dims_d.sf) < OneFx;
  end

  // Settled values need no reset: busy holds the input off until they are loaded.
  always_ff @(posedge clk_i) begin
    dims_q <= dims_d;
  end

  assign dims_o = dims_q;
  assign busy_o = busy_q;

endmodule

// File: rtl/nnsm_step.sv
// Per-pixel step of the scale mapper: frame position, accumulators, copy counts, result register.
// Depends on nnsm_pkg, nnsm_pix_if and nnsm_res_if.
`timescale 1ns / 1ps

module nnsm_step
  import nnsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  nnsm_dims_t dims_i,
  input  logic       hold_i,
  nnsm_pix_if.sink   pix,
  nnsm_res_if.source res
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CLW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int RLW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam logic [SUM_W-1:0] OneM1 = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

  logic [CW-1:0]     col_idx_q, col_idx_d;
  logic [RW-1:0]     row_idx_q, row_idx_d;
  logic [ACC_W-1:0]  col_acc_q, col_acc_d;
  logic [ACC_W-1:0]  row_acc_q, row_acc_d;
  logic [EMIT_W-1:0] emitted_q, emitted_d;
  logic [CNT_W-1:0]  rcopy_q, rcopy_d;
  logic              out_valid_q;

  logic [PIX_W-1:0]  pix_q;
  logic [CNT_W-1:0]  ccopy_q, rcopy_out_q;
  logic              row_end_q, frame_end_q;
  logic [1:0]        pad_q;

  logic              accept;
  logic [CW:0]       col_nxt;
  logic [RW:0]       row_nxt;
  logic              last_col, last_row;
  logic [SUM_W-1:0]  sf_x, hout_x, wout_x, emitted_x;
  logic [SUM_W-1:0]  row_cur, row_a, row_b, row_ca, row_cb;
  logic              row_step;
  logic [SUM_W-1:0]  col_b, col_cb;
  logic [CNT_W-1:0]  rc, cols;

  assign pix.ready = !hold_i && (!out_valid_q || res.ready);
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    sf_x      = SUM_W'(dims_i.sf);
    hout_x    = SUM_W'(dims_i.hout);
    wout_x    = SUM_W'(dims_i.wout);
    emitted_x = SUM_W'(emitted_q);

    // Row copies: evaluated from the row accumulator, taken at the first pixel of a row.
    row_cur  = SUM_W'(row_acc_q) >> FRAC_BITS;
    row_step = (SUM_W'(row_acc_q) < sf_x) ||
               (((SUM_W'(row_acc_q) - sf_x) >> FRAC_BITS) != row_cur);
    row_ca   = (SUM_W'(row_acc_q) + OneM1) >> FRAC_BITS;
    row_cb   = (SUM_W'(row_acc_q) + sf_x + OneM1) >> FRAC_BITS;
    row_a    = (row_ca < hout_x) ? row_ca : hout_x;
    row_b    = (row_cb < hout_x) ? row_cb : hout_x;
    if (dims_i.reduce) begin
      rc = CNT_W'(row_step && (row_cur < hout_x));
    end else if (row_b > row_a) begin
      rc = CNT_W'(row_b - row_a);
    end else begin
      rc = '0;
    end
    rcopy_d = (col_idx_q == '0) ? rc : rcopy_q;

    // Column copies against the count already emitted in this row.
    col_cb = (SUM_W'(col_acc_q) + sf_x + OneM1) >> FRAC_BITS;
    col_b  = (col_cb < wout_x) ? col_cb : wout_x;
    if (dims_i.reduce) begin
      if (((SUM_W'(col_acc_q) >> FRAC_BITS) == emitted_x) && (emitted_x < wout_x)) begin
        cols      = CNT_W'(1);
        emitted_d = emitted_q + EMIT_W'(1);
      end else begin
        cols      = '0;
        emitted_d = emitted_q;
      end
    end else if (col_b > emitted_x) begin
      cols      = CNT_W'(col_b - emitted_x);
      emitted_d = col_b[EMIT_W-1:0];
    end else begin
      cols      = '0;
      emitted_d = emitted_q;
    end

    col_nxt  = (CW + 1)'(col_idx_q) + (CW + 1)'(1);
    row_nxt  = (RW + 1)'(row_idx_q) + (RW + 1)'(1);
    last_col = CLW'(col_nxt) >= CLW'(dims_i.w);
    last_row = RLW'(row_nxt) >= RLW'(dims_i.h);

    // Advance the frame position.
    col_idx_d = col_nxt[CW-1:0];
    row_idx_d = row_idx_q;
    col_acc_d = col_acc_q + ACC_W'(dims_i.sf);
    row_acc_d = row_acc_q;
    if (last_col) begin
      col_idx_d = '0;
      col_acc_d = '0;
      emitted_d = '0;
      if (last_row) begin
        row_idx_d = '0;
        row_acc_d = '0;
      end else begin
        row_idx_d = row_nxt[RW-1:0];
        row_acc_d = row_acc_q + ACC_W'(dims_i.sf);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_idx_q   <= '0;
      row_idx_q   <= '0;
      col_acc_q   <= '0;
      row_acc_q   <= '0;
      emitted_q   <= '0;
      rcopy_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_idx_q   <= col_idx_d;
        row_idx_q   <= row_idx_d;
        col_acc_q   <= col_acc_d;
        row_acc_q   <= row_acc_d;
        emitted_q   <= emitted_d;
        rcopy_q     <= rcopy_d;
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q       <= pix.pixel;
      ccopy_q     <= cols;
      rcopy_out_q <= rcopy_d;
      row_end_q   <= last_col;
      frame_end_q <= last_col && last_row;
      pad_q       <= last_col ? dims_i.wout[1:0] : 2'b00;
    end
  end

  assign res.valid      = out_valid_q;
  assign res.pixel_out  = pix_q;
  assign res.col_copies = ccopy_q;
  assign res.row_copies = rcopy_out_q;
  assign res.row_end    = row_end_q;
  assign res.pad_bytes  = pad_q;
  assign res.frame_end  = frame_end_q;

endmodule

// File: rtl/nearest_neighbor_scale_mapper.sv
// Top level of the nearest-neighbour scale mapper.
// Depends on nnsm_pkg, nnsm_pix_if, nnsm_res_if, nnsm_cfg and nnsm_step.
`timescale 1ns / 1ps

// Takes 24-bit pixels in raster order and returns each one with the number of
// output columns it fills and the number of output rows its input row fills,
// for a scale factor in unsigned fixed point with FRAC_BITS fraction bits.
// One item is accepted per clock while the input is not held off and the sink
// keeps up, and its result appears in the output register in the next cycle; the
// rate is set by the per-pixel accumulator add and the ceiling/compare logic
// between the frame state and that register. The output register lets a new
// item in while the previous result waits, as long as the sink takes it in the
// same cycle. Row ends carry the padding byte count of the output row (output
// width mod 4). Write the registers only between frames with no result
// pending; after any write the input is held off while the clamped settings
// and output dimensions (two 13x23 multiplies) settle; likewise after reset.

module nearest_neighbor_scale_mapper
  import nnsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  nnsm_pix_if.sink         pixel_i,
  nnsm_res_if.source       result_o
);

  nnsm_dims_t dims;
  logic       cfg_busy;

  nnsm_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .dims_o     (dims),
    .busy_o     (cfg_busy)
  );

  // Hold the input while a write lands or the settled values are reloading.
  nnsm_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .dims_i(dims),
    .hold_i(cfg_busy || cfg_we_i),
    .pix   (pixel_i),
    .res   (result_o)
  );

endmodule

// File: dv/tb.sv
// Self-checking bench for the nearest-neighbour scale mapper: pixels in, copy counts out.
// Depends on nnsm_pkg, nnsm_pix_if, nnsm_res_if and nearest_neighbor_scale_mapper.
`timescale 1ns / 1ps

localparam int unsigned TB_FRAC = 16;
localparam int unsigned TB_MAX_W = 4096;
localparam int unsigned TB_MAX_H = 4096;
localparam longint unsigned UNITY_FX = 64'd1 << TB_FRAC;
localparam longint unsigned TOP_FACTOR = 64'd100 << TB_FRAC;
localparam longint unsigned ACC_MASK = 64'hF_FFFF_FFFF;
localparam longint unsigned EMIT_MASK = 64'hF_FFFF;

// One result item as the block presents it.
typedef struct packed {
  logic [23:0] pixel;
  logic [6:0]  col;
  logic [6:0]  row;
  logic        row_end;
  logic [1:0]  pad;
  logic        frame_end;
} mapped_pixel_t;

// Tracks the raster position and the accumulators, predicts each result item
// and holds the predictions until the block delivers them.
class scale_scoreboard;
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  logic [22:0] reg_factor;
  int unsigned col_pos;
  int unsigned row_pos;
  longint unsigned col_acc;
  longint unsigned row_acc;
  longint unsigned cols_out;
  logic [6:0] row_count;
  mapped_pixel_t expected_q[$];
  int errors;
  int checked;
  int row_ends;
  int frame_ends;
  longint unsigned widest_fill;

  function new();
    reg_width = 13'd1;
    reg_height = 13'd1;
    reg_factor = 23'(UNITY_FX);
    col_pos = 0;
    row_pos = 0;
    col_acc = 0;
    row_acc = 0;
    cols_out = 0;
    row_count = '0;
    errors = 0;
    checked = 0;
    row_ends = 0;
    frame_ends = 0;
    widest_fill = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void set_reg(nnsm_pkg::cfg_idx_e idx, logic [22:0] data);
    case (idx)
      nnsm_pkg::CFG_IN_WIDTH:     reg_width = data[12:0];
      nnsm_pkg::CFG_IN_HEIGHT:    reg_height = data[12:0];
      nnsm_pkg::CFG_SCALE_FACTOR: reg_factor = data;
      default: ;
    endcase
  endfunction

  function longint unsigned clamp_dim(longint unsigned v, longint unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function longint unsigned ceil_fx(longint unsigned x);
    return (x + UNITY_FX - 1) >> TB_FRAC;
  endfunction

  function longint unsigned min64(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  function void note_pixel(logic [23:0] px);
    longint unsigned w, h, sf, wout, hout, cols, a, b, cur, rc;
    bit shrink, stepped, last_col, last_row;
    mapped_pixel_t e;
    w = clamp_dim(reg_width, TB_MAX_W);
    h = clamp_dim(reg_height, TB_MAX_H);
    if (reg_factor == 0) sf = 1;
    else sf = (reg_factor > TOP_FACTOR) ? TOP_FACTOR : reg_factor;
    wout = (w * sf) >> TB_FRAC;
    hout = (h * sf) >> TB_FRAC;
    shrink = sf < UNITY_FX;
    cols = 0;

    // latch the row count on the first pixel of each row
    if (col_pos == 0) begin
      cur = row_acc >> TB_FRAC;
      if (shrink) begin
        stepped = (row_acc < sf) || (((row_acc - sf) >> TB_FRAC) != cur);
        rc = (stepped && cur < hout) ? 1 : 0;
      end else begin
        a = min64(ceil_fx(row_acc), hout);
        b = min64(ceil_fx(row_acc + sf), hout);
        rc = (b > a) ? b - a : 0;
      end
      row_count = rc[6:0];
    end

    if (shrink) begin
      if ((col_acc >> TB_FRAC) == cols_out && cols_out < wout) cols = 1;
    end else begin
      b = min64(ceil_fx(col_acc + sf), wout);
      cols = (b > cols_out) ? b - cols_out : 0;
    end
    cols_out = (cols_out + cols) & EMIT_MASK;
    if (cols > widest_fill) widest_fill = cols;

    last_col = (64'(col_pos) + 1) >= w;
    last_row = (64'(row_pos) + 1) >= h;

    e.pixel = px;
    e.col = cols[6:0];
    e.row = row_count;
    e.row_end = last_col;
    e.pad = last_col ? wout[1:0] : 2'd0;
    e.frame_end = last_col && last_row;
    expected_q.push_back(e);

    if (last_col) begin
      col_pos = 0;
      col_acc = 0;
      cols_out = 0;
      if (last_row) begin
        row_pos = 0;
        row_acc = 0;
      end else begin
        row_pos++;
        row_acc = (row_acc + sf) & ACC_MASK;
      end
    end else begin
      col_pos++;
      col_acc = (col_acc + sf) & ACC_MASK;
    end
  endfunction

  task report(string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task compare(string field, logic [23:0] got, logic [23:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", checked, field, got, want));
  endtask

  task check_result(mapped_pixel_t got);
    mapped_pixel_t want;
    checked++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding", checked));
      return;
    end
    want = expected_q.pop_front();
    compare("pixel_out", got.pixel, want.pixel);
    compare("col_copies", 24'(got.col), 24'(want.col));
    compare("row_copies", 24'(got.row), 24'(want.row));
    compare("row_end", 24'(got.row_end), 24'(want.row_end));
    compare("pad_bytes", 24'(got.pad), 24'(want.pad));
    compare("frame_end", 24'(got.frame_end), 24'(want.frame_end));
    if (want.row_end) row_ends++;
    if (want.frame_end) frame_ends++;
  endtask
endclass

module tb;
  import nnsm_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 300;   // long output stall to back the block up
  localparam int PRESSURE_AT = 900;   // offered item count that triggers the stall
  localparam int RANDOM_ITEMS = 1600;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  nnsm_pix_if pix_if ();
  nnsm_res_if res_if ();

  nearest_neighbor_scale_mapper #(
    .MAX_WIDTH (TB_MAX_W),
    .MAX_HEIGHT(TB_MAX_H)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pixel_i    (pix_if),
    .result_o   (res_if)
  );

  scale_scoreboard sb;

  int burst_left = 0;
  int offered = 0;
  int n_settings = 0;
  int idle_cycles = 0;
  int holds_done = 0;
  bit hold_req = 1'b0;
  bit pressure_armed = 1'b0;
  bit moved;
  mapped_pixel_t seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor and watchdog. Check the result before noting the input of the
  // same edge: a result always belongs to an earlier item.
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (res_if.valid && res_if.ready) begin
        seen.pixel = res_if.pixel_out;
        seen.col = res_if.col_copies;
        seen.row = res_if.row_copies;
        seen.row_end = res_if.row_end;
        seen.pad = res_if.pad_bytes;
        seen.frame_end = res_if.frame_end;
        sb.check_result(seen);
        moved = 1'b1;
      end
      if (pix_if.valid && pix_if.ready) begin
        sb.note_pixel(pix_if.pixel);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: stalled for %0d cycles with %0d items outstanding",
                 idle_cycles, sb.pending());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver: change stall pattern over spans of random length, and honour one
  // long hold-off so the output register fills and the input backs up.
  initial begin : sink_side
    sink_mode_e mode;
    int span;
    int period;
    int k;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          res_if.ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
        holds_done++;
      end
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(8, 120);
      period = $urandom_range(1, 6);
      for (k = 0; k < span && !hold_req; k++) begin
        case (mode)
          SINK_OPEN:   res_if.ready <= 1'b1;
          SINK_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:     res_if.ready <= ((k / period) % 2) == 0;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(0, 15))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly factors near unity, with both ends of the legal range mixed in.
  function automatic logic [22:0] pick_factor();
    case ($urandom_range(0, 9))
      0:       return 23'd1;
      1:       return 23'(TOP_FACTOR);
      2:       return 23'($urandom_range(1, 4)) << TB_FRAC;
      3:       return 23'($urandom_range(1, 100)) << TB_FRAC;
      4:       return 23'($urandom_range(1, 32'hFFFF));
      5:       return 23'($urandom_range(32'h8000, 32'h40000));
      6:       return 23'($urandom_range(1, 6553600));
      7:       return 23'(UNITY_FX);
      8:       return 23'($urandom_range(32'h4000, 32'hFFFF));
      default: return 23'($urandom_range(32'h10001, 32'h30000));
    endcase
  endfunction

  // Offer one pixel; open a gap first when the current burst is used up.
  task automatic offer(input logic [23:0] px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 300)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
    offered++;
    if (!pressure_armed && offered == PRESSURE_AT) begin
      hold_req = 1'b1;
      pressure_armed = 1'b1;
    end
  endtask

  // Drop valid and wait until every outstanding item has come back. The extra
  // edge lets the monitor note the last accepted item first.
  task automatic drain();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leave the write enable high; the caller drops it after its last write.
  task automatic write_reg(input cfg_idx_e idx, input logic [22:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Idle the block, then write all three registers. The upper bits of the
  // dimension writes carry junk that the block must ignore.
  task automatic configure(input logic [12:0] w, input logic [12:0] h,
                           input logic [22:0] sf, input bit poke_unused);
    drain();
    if (poke_unused) write_reg(CFG_UNUSED, 23'($urandom));
    write_reg(CFG_IN_WIDTH, {10'($urandom), w});
    write_reg(CFG_IN_HEIGHT, {10'($urandom), h});
    write_reg(CFG_SCALE_FACTOR, sf);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Change the factor alone, wherever the raster position happens to be.
  task automatic retune_factor(input logic [22:0] sf);
    drain();
    write_reg(CFG_SCALE_FACTOR, sf);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : source_side
    int r;
    int w;
    int h;
    int n;
    int random_start;
    logic [22:0] sf;

    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IN_WIDTH;
    cfg_wdata = '0;
    rst_n = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one by one pixel at unity factor.
    offer(24'h000000);
    offer(24'hFFFFFF);

    // Zero dimensions and zero factor fall back to 1 and the smallest step.
    configure(13'd0, 13'd0, 23'd0, 1'b0);
    offer(random_pixel());
    offer(random_pixel());

    // Oversize everything: width and height saturate, factor clamps to 100.
    configure(13'h1FFF, 13'h1FFF, 23'h7FFFFF, 1'b0);
    repeat (3) offer(random_pixel());

    // Shrink the width mid-row: the next pixel sits past the new last column.
    drain();
    write_reg(CFG_IN_WIDTH, 23'd2);
    cfg_we <= 1'b0;
    offer(random_pixel());
    offer(random_pixel());

    // Change the factor mid-frame: accumulators keep their sums.
    retune_factor(23'h18000);
    offer(random_pixel());
    offer(random_pixel());

    // Non-integer enlargement, then reduction, on a small frame.
    configure(13'd3, 13'd2, 23'h18000, 1'b0);
    repeat (6) offer(random_pixel());
    configure(13'd3, 13'd2, 23'h0C000, 1'b0);
    repeat (6) offer(random_pixel());

    // Tall single column at the largest factor; hit the spare register index.
    configure(13'd1, 13'd4096, 23'(TOP_FACTOR), 1'b1);
    offer(random_pixel());
    offer(random_pixel());

    // Random phases: mostly whole small frames, some cut short, some huge
    // dimensions, some out-of-range register values.
    random_start = offered;
    while (offered - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      sf = pick_factor();
      if (r < 6) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        n = $urandom_range(1, 3) * w * h;
      end else if (r < 8) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        n = $urandom_range(1, w * h);
      end else if (r == 8) begin
        if ($urandom_range(0, 1) == 1) begin
          w = ($urandom_range(0, 1) == 1) ? 4096 : $urandom_range(4097, 8191);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 3);
          h = ($urandom_range(0, 1) == 1) ? 4096 : $urandom_range(4097, 8191);
        end
        n = $urandom_range(20, 80);
      end else begin
        w = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
        h = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 1)
          sf = ($urandom_range(0, 1) == 1) ? 23'd0 : 23'($urandom_range(6553601, 23'h7FFFFF));
        n = $urandom_range(1, 20);
      end
      if (r >= 6 && $urandom_range(0, 3) == 0)
        retune_factor(sf);
      else
        configure(13'(w), 13'(h), sf, $urandom_range(0, 7) == 0);
      repeat (n) offer(random_pixel());
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("tb: %0d pixels over %0d register settings, %0d results checked",
             offered, n_settings, sb.checked);
    $display("tb: %0d row ends, %0d frame ends, widest column fill %0d, %0d long output stall",
             sb.row_ends, sb.frame_ends, sb.widest_fill, holds_done);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
